>>> design/hms_pkg.sv
`default_nettype none

package hms_pkg;

  localparam int unsigned SecW   = 8;
  localparam int unsigned MinW   = 6;
  localparam int unsigned HrW    = 5;
  localparam int unsigned DriftW = 18;

  localparam logic [SecW-1:0]   SecLast   = 8'd59;
  localparam logic [SecW-1:0]   SecHeld   = 8'd255;
  localparam logic [MinW-1:0]   MinLast   = 6'd59;
  localparam logic [HrW-1:0]    HrLast    = 5'd23;
  localparam logic [DriftW-1:0] DriftMax  = 18'h3FFFF;
  localparam logic [DriftW-1:0] DriftRst  = 18'd172799;

  // Bit positions of the request fields in the input tdata.
  localparam int unsigned InTickBit = 0;
  localparam int unsigned InMinBit  = 1;
  localparam int unsigned InHrBit   = 2;

  // Time-of-day and drift state.
  typedef struct packed {
    logic [SecW-1:0]   sec;
    logic [MinW-1:0]   min;
    logic [HrW-1:0]    hr;
    logic [DriftW-1:0] drift;
  } hms_state_t;

  // One request from the input stage.
  typedef struct packed {
    logic tick;
    logic min_btn;
    logic hr_btn;
  } hms_req_t;

  // Active-low lamp patterns of one result.
  typedef struct packed {
    logic [HrW-1:0]  hours_leds;
    logic [MinW-1:0] minutes_leds;
    logic [5:0]      seconds_leds;
  } hms_leds_t;

endpackage

`default_nettype wire

>>> design/hms_step.sv
`default_nettype none

module hms_step (
  input  hms_pkg::hms_state_t  state_i,
  input  hms_pkg::hms_req_t    req_i,
  input  logic [17:0]          drift_limit_i,
  output hms_pkg::hms_state_t  state_o,
  output hms_pkg::hms_leds_t   leds_o
);
  import hms_pkg::*;

  logic [SecW-1:0]   sec_inc;
  logic [SecW-1:0]   sec_corr;
  logic [DriftW-1:0] drift_inc;
  logic              corr_fire;
  logic [MinW-1:0]   min_inc;
  logic              min_wrap;
  logic [HrW-1:0]    hr_inc;
  logic              hr_wrap;
  hms_state_t        tick_st;
  logic [MinW-1:0]   btn_min_inc;
  logic [HrW-1:0]    btn_hr_inc;

  // Tick path: advance seconds and drift, apply the drop-one-second correction, and carry into minutes and hours.
  always_comb begin
    sec_inc   = state_i.sec + 8'd1;
    drift_inc = (state_i.drift < DriftMax) ? state_i.drift + 18'd1 : state_i.drift;
    corr_fire = (drift_inc > drift_limit_i) && (sec_inc != '0);
    sec_corr  = corr_fire ? sec_inc - 8'd1 : sec_inc;

    min_inc  = state_i.min + 6'd1;
    min_wrap = min_inc > MinLast;
    hr_inc   = state_i.hr + 5'd1;
    hr_wrap  = hr_inc > HrLast;

    tick_st       = state_i;
    tick_st.drift = corr_fire ? '0 : drift_inc;
    tick_st.sec   = sec_corr;
    if (sec_corr > SecLast) begin
      tick_st.sec = '0;
      tick_st.min = min_wrap ? '0 : min_inc;
      if (min_wrap) begin
        tick_st.hr = hr_wrap ? '0 : hr_inc;
      end
    end
    if (!req_i.tick) begin
      tick_st = state_i;
    end
  end

  // Button path acts on the state left by the tick; minute wins over hour.
  always_comb begin
    btn_min_inc = tick_st.min + 6'd1;
    btn_hr_inc  = tick_st.hr + 5'd1;
    state_o     = tick_st;
    if (req_i.min_btn) begin
      state_o.min = (btn_min_inc > MinLast) ? '0 : btn_min_inc;
      state_o.sec = SecHeld;
    end else if (req_i.hr_btn) begin
      state_o.hr = (btn_hr_inc > HrLast) ? '0 : btn_hr_inc;
    end
    leds_o.seconds_leds = ~state_o.sec[5:0];
    leds_o.minutes_leds = ~state_o.min;
    leds_o.hours_leds   = ~state_o.hr;
  end

endmodule

`default_nettype wire

>>> design/hms_clock_with_drift_correction_core.sv
// Time-of-day clock (hours, minutes, seconds) with periodic drift correction.
// Each input request is one pass of the control loop and carries a one-second
// tick and the minute and hour set buttons. Each request produces exactly one
// result holding the active-low lamp patterns of seconds, minutes and hours.
// The input channel (s_axis_*) and output channel (m_axis_*) use a valid/ready
// handshake. A request is captured in an input register, the whole update is
// done in one pass of short logic, and the result lands in an output register
// that drives tvalid on the output. Throughput is one request per cycle while
// the receiver does not stall; the time registers update in the same edge that
// loads the result, so back-to-back requests see each other's state. When the
// receiver stalls, the output register holds its result and the input register
// fills; tready drops only when both are occupied and not draining. Reset clears
// the time and drift counters and loads the drift limit with its default of 172799
// seconds. The user must write the drift limit through drift_limit_we_i only while
// the block is idle; the block does not enforce this. It takes effect on the next tick.
`default_nettype none

module hms_clock_with_drift_correction_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Drift limit register write port.
  input  logic        drift_limit_we_i,
  input  logic [17:0] drift_limit_i,
  // Input requests.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] second_tick, [1] minute_button, [2] hour_button
  // Results.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [5:0] seconds_leds, [11:6] minutes_leds,
                                      // [16:12] hours_leds, rest zero
);
  import hms_pkg::*;

  logic [DriftW-1:0] limit_q;
  hms_state_t        state_q;
  hms_state_t        state_d;
  logic              in_valid_q;
  hms_req_t          in_req_q;
  logic              out_valid_q;
  hms_leds_t         out_leds_q;
  hms_leds_t         leds_d;
  logic              out_free;
  logic              fire;
  logic              in_take;

  // The output register can load when empty or draining this cycle.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || fire;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  hms_step u_step (
    .state_i       (state_q),
    .req_i         (in_req_q),
    .drift_limit_i (limit_q),
    .state_o       (state_d),
    .leds_o        (leds_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= DriftRst;
    end else if (drift_limit_we_i) begin
      limit_q <= drift_limit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        state_q <= state_d;
      end
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_req_q.tick    <= s_axis_tdata[InTickBit];
      in_req_q.min_btn <= s_axis_tdata[InMinBit];
      in_req_q.hr_btn  <= s_axis_tdata[InHrBit];
    end
    if (fire) begin
      out_leds_q <= leds_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_leds_q};

`ifndef SYNTHESIS
  // Hours and minutes never leave their ranges.
  assert property (@(posedge clk_i) disable iff (!rst_ni) state_q.hr <= HrLast)
    else $error("hours count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni) state_q.min <= MinLast)
    else $error("minutes count out of range");
  // Seconds are either a valid count or the held marker.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.sec <= SecLast) || (state_q.sec == SecHeld))
    else $error("seconds count out of range");
  // Every processed request shows up as a result on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fire |=> m_axis_tvalid)
    else $error("processed request lost its result");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_hms_clock_with_drift_correction_core.sv
`default_nettype none

module tb_hms_clock_with_drift_correction_core;

  import hms_pkg::*;

  // The watchdog ends the run here.
  localparam int CycleLimit = 200_000;

  // Ticks in the phase with the limit at its top value.
  localparam int SatTicks = 20;

  localparam int NumPhases = 6;

  logic        clk_i;
  logic        rst_ni           = 1'b0;
  logic        drift_limit_we_i = 1'b0;
  logic [17:0] drift_limit_i    = '0;
  logic        s_axis_tvalid    = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata     = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready    = 1'b0;
  logic [23:0] m_axis_tdata;

  hms_clock_with_drift_correction_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .drift_limit_we_i (drift_limit_we_i),
    .drift_limit_i    (drift_limit_i),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Requests waiting to be offered, and lamp patterns waiting to come back.
  hms_req_t  pending_reqs[$];
  hms_leds_t expected_leds[$];

  // Our own copy of the time of day, the drift counter and the drift limit.
  logic [SecW-1:0]   tod_sec   = '0;
  logic [MinW-1:0]   tod_min   = '0;
  logic [HrW-1:0]    tod_hr    = '0;
  logic [DriftW-1:0] tod_drift = '0;
  logic [DriftW-1:0] tod_limit = DriftRst;

  // Odds of starting an idle burst, one in N per cycle. Zero turns idling off.
  int idle_odds  = 3;
  int stall_odds = 3;
  int gap_left   = 0;
  int stall_left = 0;

  int cycle_count    = 0;
  int mismatch_count = 0;

  // Applies one request to the time of day and returns the lamp patterns that
  // the block should show afterwards.
  function automatic hms_leds_t advance_clock(input hms_req_t req);
    hms_leds_t leds;
    if (req.tick) begin
      // The held value 255 wraps to zero here, which is what makes the first
      // tick after a minute press show zero seconds.
      tod_sec = tod_sec + 8'd1;
      if (tod_drift != DriftMax) begin
        tod_drift = tod_drift + 18'd1;
      end
      // Drop one second once the drift count is past the limit. At zero
      // seconds the correction is put off to a later tick.
      if (tod_drift > tod_limit && tod_sec != '0) begin
        tod_sec   = tod_sec - 8'd1;
        tod_drift = '0;
      end
      if (tod_sec > SecLast) begin
        tod_sec = '0;
        if (tod_min == MinLast) begin
          tod_min = '0;
          tod_hr  = (tod_hr == HrLast) ? '0 : tod_hr + 5'd1;
        end else begin
          tod_min = tod_min + 6'd1;
        end
      end
    end
    // The minute button wins over the hour button. A minute press never
    // carries into the hours, and it leaves the seconds held.
    if (req.min_btn) begin
      tod_min = (tod_min == MinLast) ? '0 : tod_min + 6'd1;
      tod_sec = SecHeld;
    end else if (req.hr_btn) begin
      tod_hr = (tod_hr == HrLast) ? '0 : tod_hr + 5'd1;
    end
    leds.seconds_leds = ~tod_sec[5:0];
    leds.minutes_leds = ~tod_min;
    leds.hours_leds   = ~tod_hr;
    return leds;
  endfunction

  // Prints one line per mismatch and counts every one.
  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    $display("mismatch at cycle %0d: %s: got %h, want %h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // Waits until every request has been taken and every result has come back.
  task automatic wait_idle();
    do begin
      @(negedge clk_i);
    end while (pending_reqs.size() != 0 || s_axis_tvalid || expected_leds.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes the drift limit while the block is idle. The write lands at the
  // rising edge at which the write enable is seen high.
  task automatic write_drift_limit(input logic [DriftW-1:0] value);
    wait_idle();
    @(posedge clk_i);
    drift_limit_we_i <= 1'b1;
    drift_limit_i    <= value;
    @(posedge clk_i);
    drift_limit_we_i <= 1'b0;
    tod_limit = value;
  endtask

  task automatic push_req(input logic [2:0] code);
    hms_req_t req;
    req.tick    = code[InTickBit];
    req.min_btn = code[InMinBit];
    req.hr_btn  = code[InHrBit];
    pending_reqs.push_back(req);
  endtask

  // Queues about n requests made of runs. Most runs are ticks long enough to
  // carry seconds into minutes; minute-press runs bring the minutes near the
  // rollover so that ticks then carry into the hours. Hour-press runs wrap the
  // hours, and a few runs are plain noise.
  task automatic queue_traffic(input int n);
    int       added;
    int       kind;
    int       run_len;
    hms_req_t req;
    added = 0;
    while (added < n) begin
      kind = $urandom_range(99, 0);
      if (kind < 60) begin
        run_len = $urandom_range(80, 1);
      end else if (kind < 80) begin
        run_len = $urandom_range(25, 1);
      end else if (kind < 92) begin
        run_len = $urandom_range(12, 1);
      end else begin
        run_len = $urandom_range(6, 1);
      end
      repeat (run_len) begin
        if (kind < 60) begin
          req.tick    = 1'b1;
          req.min_btn = 1'b0;
          req.hr_btn  = ($urandom_range(15, 0) == 0);
        end else if (kind < 80) begin
          req.tick    = ($urandom_range(3, 0) == 0);
          req.min_btn = 1'b1;
          req.hr_btn  = 1'($urandom_range(1, 0));
        end else if (kind < 92) begin
          req.tick    = ($urandom_range(3, 0) == 0);
          req.min_btn = 1'b0;
          req.hr_btn  = 1'b1;
        end else begin
          req.tick    = 1'($urandom_range(1, 0));
          req.min_btn = 1'($urandom_range(1, 0));
          req.hr_btn  = 1'($urandom_range(1, 0));
        end
        pending_reqs.push_back(req);
        added++;
      end
    end
  endtask

  // Request driver. When a request is taken, the predictor is advanced with it
  // and its lamp patterns are queued. A new request is offered only once the
  // previous one is gone, so tvalid never drops while a request is waiting.
  always @(posedge clk_i) begin : request_driver
    logic       next_valid;
    logic [7:0] next_data;
    hms_req_t   req;
    hms_req_t   taken;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        taken.tick    = s_axis_tdata[InTickBit];
        taken.min_btn = s_axis_tdata[InMinBit];
        taken.hr_btn  = s_axis_tdata[InHrBit];
        expected_leds.push_back(advance_clock(taken));
      end
      next_valid = s_axis_tvalid;
      next_data  = s_axis_tdata;
      if (!s_axis_tvalid || s_axis_tready) begin
        next_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (idle_odds != 0 && $urandom_range(idle_odds, 1) == 1) begin
          // This cycle is the first of an idle burst.
          gap_left = $urandom_range(19, 1) - 1;
        end else if (pending_reqs.size() != 0) begin
          req                  = pending_reqs.pop_front();
          next_valid           = 1'b1;
          next_data            = '0;
          next_data[InTickBit] = req.tick;
          next_data[InMinBit]  = req.min_btn;
          next_data[InHrBit]   = req.hr_btn;
        end
      end
      s_axis_tvalid <= next_valid;
      s_axis_tdata  <= next_data;
    end
  end

  // Result monitor. Every result taken is checked field by field against the
  // oldest expectation. Ready is dropped in random bursts.
  always @(posedge clk_i) begin : result_monitor
    hms_leds_t want;
    hms_leds_t got;
    logic      next_ready;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[16:0];
        if (expected_leds.size() == 0) begin
          report_mismatch("result with no request behind it", m_axis_tdata, '0);
        end else begin
          want = expected_leds.pop_front();
          if (got.seconds_leds !== want.seconds_leds) begin
            report_mismatch("seconds_leds", 24'(got.seconds_leds),
                            24'(want.seconds_leds));
          end
          if (got.minutes_leds !== want.minutes_leds) begin
            report_mismatch("minutes_leds", 24'(got.minutes_leds),
                            24'(want.minutes_leds));
          end
          if (got.hours_leds !== want.hours_leds) begin
            report_mismatch("hours_leds", 24'(got.hours_leds), 24'(want.hours_leds));
          end
          if (m_axis_tdata[23:17] !== '0) begin
            report_mismatch("padding bits", 24'(m_axis_tdata[23:17]), '0);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else if (stall_odds != 0 && $urandom_range(stall_odds, 1) == 1) begin
        stall_left = $urandom_range(19, 1) - 1;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      m_axis_tready <= next_ready;
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Stimulus sequence. Each phase sets a drift limit while the block is idle,
  // picks how often both sides idle, and then queues its requests.
  initial begin : stimulus
    logic [DriftW-1:0] phase_limit [NumPhases];
    int                phase_odds  [NumPhases];
    hms_req_t          req;
    int                i;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests at the reset limit: every combination of the three
    // request bits, a minute press holding the seconds and the tick that
    // clears them, both buttons together, and buttons on a tick.
    @(negedge clk_i);
    push_req(3'b000);
    push_req(3'b001);
    push_req(3'b001);
    push_req(3'b100);
    push_req(3'b100);
    push_req(3'b010);
    push_req(3'b001);
    push_req(3'b001);
    push_req(3'b110);
    push_req(3'b001);
    push_req(3'b011);
    push_req(3'b001);
    push_req(3'b101);
    push_req(3'b111);
    push_req(3'b010);
    push_req(3'b010);
    push_req(3'b000);
    push_req(3'b001);
    push_req(3'b101);
    push_req(3'b011);
    push_req(3'b111);
    push_req(3'b110);
    push_req(3'b100);
    push_req(3'b001);

    // A limit of zero makes the correction fire on every tick that leaves the
    // seconds nonzero, and one makes it fire on every other tick. One phase
    // runs with no idling at all.
    phase_limit[0] = '0;
    phase_limit[1] = 18'd1;
    phase_limit[2] = 18'($urandom_range(70, 2));
    phase_limit[3] = DriftMax - 18'd1;
    phase_limit[4] = 18'(SecLast);
    phase_limit[5] = 18'($urandom_range(262142, 0));
    phase_odds[0]  = 4;
    phase_odds[1]  = 6;
    phase_odds[2]  = 0;
    phase_odds[3]  = 3;
    phase_odds[4]  = 10;
    phase_odds[5]  = 5;
    for (i = 0; i < NumPhases; i++) begin
      write_drift_limit(phase_limit[i]);
      idle_odds  = phase_odds[i];
      stall_odds = phase_odds[i];
      queue_traffic(55);
    end

    // With the limit at its top value the correction never fires. The last
    // part of the run has no idling.
    write_drift_limit(DriftMax);
    idle_odds  = 0;
    stall_odds = 0;
    for (i = 0; i < SatTicks; i++) begin
      req.tick    = 1'b1;
      req.min_btn = ($urandom_range(7, 0) == 0);
      req.hr_btn  = ($urandom_range(7, 0) == 0);
      pending_reqs.push_back(req);
    end

    // A small limit again, so the correction fires with no idling at all.
    write_drift_limit(18'd2);
    queue_traffic(25);

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (expected_leds.size() != 0) begin
      report_mismatch("results never produced", 24'(expected_leds.size()), '0);
    end
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
